>>> rtl/assert_macros.svh
// Assertion helpers for the patch decoder. Both forms are compiled away in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define IPD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IPD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define IPD_ASSERT(label, clk, rst_n, prop, msg)
`define IPD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif

`endif

>>> rtl/ipd_pkg.sv
package ipd_pkg;

    typedef enum logic [2:0] {
        KIND_WRITE     = 3'd0,
        KIND_FILL      = 3'd1,
        KIND_DONE      = 3'd2,
        KIND_BAD_MAGIC = 3'd3,
        KIND_TRUNCATED = 3'd4
    } ipd_kind_t;

    typedef struct packed {
        ipd_kind_t   kind;
        logic [31:0] address;
        logic [15:0] length;
        logic [7:0]  value;
        logic        last;
    } ipd_result_t;

    // Results of one accepted item; the second is valid only with the first.
    typedef struct packed {
        logic        v0;
        logic        v1;
        ipd_result_t r0;
        ipd_result_t r1;
    } ipd_push_t;

    localparam logic [31:0] MAGIC_IPS_HEAD = 32'h5041_5443;
    localparam logic [7:0]  MAGIC_IPS_TAIL = 8'h48;
    localparam logic [31:0] MAGIC_I32_HEAD = 32'h4950_5333;
    localparam logic [7:0]  MAGIC_I32_TAIL = 8'h32;
    localparam logic [31:0] END_IPS        = 32'h0045_4F46;
    localparam logic [31:0] END_I32        = 32'h4545_4F46;
    localparam logic [32:0] ADDR_SPACE     = 33'h1_0000_0000;
    localparam int          QUEUE_DEPTH    = 3;

endpackage

>>> rtl/ipd_decode.sv
module ipd_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [32:0]       cfg_wr_data,
    input  logic              accept,
    input  logic [7:0]        patch_byte,
    input  logic              first_byte,
    input  logic              final_byte,
    output ipd_pkg::ipd_push_t push
);

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_OFFSET,
        PH_SIZE,
        PH_RLE_LEN,
        PH_RLE_VAL,
        PH_DATA,
        PH_ENDED
    } phase_t;

    phase_t      phase_reg, phase_next, phase_start;
    logic        wide_reg, wide_next;
    logic [2:0]  fc_reg, fc_next;
    logic [31:0] off_reg, off_next;
    logic [15:0] left_reg, left_next;
    logic [32:0] wa_reg, wa_next;
    logic [32:0] lim_reg, lim_next;
    logic [32:0] room;
    logic [15:0] fill_len;
    logic        main_v, trunc_v;
    ipd_pkg::ipd_result_t main_r, trunc_r;

    // Room between the record offset and the image end; only used when positive.
    assign room     = lim_reg - {1'b0, off_reg};
    assign fill_len = (room[32:16] != '0 || room[15:0] >= left_reg) ? left_reg : room[15:0];
    assign lim_next = cfg_wr_data[32] ? ipd_pkg::ADDR_SPACE : cfg_wr_data;

    always_comb begin
        phase_next = phase_reg;
        wide_next  = wide_reg;
        fc_next    = fc_reg;
        off_next   = off_reg;
        left_next  = left_reg;
        wa_next    = wa_reg;
        main_v     = 1'b0;
        main_r     = '0;
        trunc_v    = 1'b0;
        trunc_r    = '0;

        if (first_byte) begin
            phase_next = PH_MAGIC;
            fc_next    = '0;
            off_next   = '0;
            wide_next  = 1'b0;
        end
        phase_start = phase_next;

        case (phase_next)
            PH_MAGIC: begin
                if (fc_next < 3'd4) begin
                    off_next = {off_next[23:0], patch_byte};
                    fc_next  = fc_next + 3'd1;
                end else if (off_next == ipd_pkg::MAGIC_IPS_HEAD &&
                             patch_byte == ipd_pkg::MAGIC_IPS_TAIL) begin
                    wide_next  = 1'b0;
                    phase_next = PH_OFFSET;
                    fc_next    = '0;
                    off_next   = '0;
                end else if (off_next == ipd_pkg::MAGIC_I32_HEAD &&
                             patch_byte == ipd_pkg::MAGIC_I32_TAIL) begin
                    wide_next  = 1'b1;
                    phase_next = PH_OFFSET;
                    fc_next    = '0;
                    off_next   = '0;
                end else begin
                    main_v      = 1'b1;
                    main_r.kind = ipd_pkg::KIND_BAD_MAGIC;
                    phase_next  = PH_ENDED;
                end
            end
            PH_OFFSET: begin
                off_next = {off_next[23:0], patch_byte};
                fc_next  = fc_next + 3'd1;
                if (fc_next >= (wide_next ? 3'd4 : 3'd3)) begin
                    fc_next = '0;
                    if (off_next == (wide_next ? ipd_pkg::END_I32 : ipd_pkg::END_IPS)) begin
                        main_v      = 1'b1;
                        main_r.kind = ipd_pkg::KIND_DONE;
                        phase_next  = PH_ENDED;
                    end else begin
                        phase_next = PH_SIZE;
                        left_next  = '0;
                    end
                end
            end
            PH_SIZE: begin
                left_next = {left_next[7:0], patch_byte};
                fc_next   = fc_next + 3'd1;
                if (fc_next >= 3'd2) begin
                    fc_next = '0;
                    if (left_next == '0) begin
                        phase_next = PH_RLE_LEN;
                    end else begin
                        phase_next = PH_DATA;
                        wa_next    = {1'b0, off_next};
                    end
                end
            end
            PH_RLE_LEN: begin
                left_next = {left_next[7:0], patch_byte};
                fc_next   = fc_next + 3'd1;
                if (fc_next >= 3'd2) begin
                    fc_next    = '0;
                    phase_next = PH_RLE_VAL;
                end
            end
            PH_RLE_VAL: begin
                if ({1'b0, off_reg} < lim_reg && left_reg != '0) begin
                    main_v         = 1'b1;
                    main_r.kind    = ipd_pkg::KIND_FILL;
                    main_r.address = off_reg;
                    main_r.length  = fill_len;
                    main_r.value   = patch_byte;
                end
                phase_next = PH_OFFSET;
                fc_next    = '0;
                off_next   = '0;
            end
            PH_DATA: begin
                // The write address is one bit wider than the offset, so a record that wraps
                // past the 32-bit space stays beyond the image end.
                if (wa_reg < lim_reg) begin
                    main_v         = 1'b1;
                    main_r.kind    = ipd_pkg::KIND_WRITE;
                    main_r.address = wa_reg[31:0];
                    main_r.length  = 16'd1;
                    main_r.value   = patch_byte;
                end
                wa_next   = wa_reg + 33'd1;
                left_next = left_reg - 16'd1;
                if (left_next == '0) begin
                    phase_next = PH_OFFSET;
                    fc_next    = '0;
                    off_next   = '0;
                end
            end
            default: begin
            end
        endcase

        if (final_byte && phase_start != PH_ENDED && phase_next != PH_ENDED) begin
            trunc_v      = 1'b1;
            trunc_r.kind = (phase_next == PH_MAGIC) ? ipd_pkg::KIND_BAD_MAGIC
                                                    : ipd_pkg::KIND_TRUNCATED;
            phase_next   = PH_ENDED;
        end
    end

    always_comb begin
        push = '0;
        if (main_v) begin
            push.v0      = accept;
            push.r0      = main_r;
            push.r0.last = !trunc_v;
            push.v1      = accept && trunc_v;
            push.r1      = trunc_r;
            push.r1.last = 1'b1;
        end else begin
            push.v0      = accept && trunc_v;
            push.r0      = trunc_r;
            push.r0.last = 1'b1;
            push.r1      = trunc_r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_MAGIC;
            wide_reg  <= 1'b0;
            fc_reg    <= '0;
            off_reg   <= '0;
            left_reg  <= '0;
            wa_reg    <= '0;
            lim_reg   <= '0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                wide_reg  <= wide_next;
                fc_reg    <= fc_next;
                off_reg   <= off_next;
                left_reg  <= left_next;
                wa_reg    <= wa_next;
            end
            if (cfg_wr_en) begin
                lim_reg <= lim_next;
            end
        end
    end

endmodule

>>> rtl/ipd_out_queue.sv
module ipd_out_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ipd_pkg::ipd_push_t   push,
    input  logic                 pop_ready,
    output logic                 head_valid,
    output ipd_pkg::ipd_result_t head,
    output logic                 has_room
);

    ipd_pkg::ipd_result_t slot_reg  [ipd_pkg::QUEUE_DEPTH];
    ipd_pkg::ipd_result_t slot_next [ipd_pkg::QUEUE_DEPTH];
    ipd_pkg::ipd_result_t shifted   [ipd_pkg::QUEUE_DEPTH];
    logic [1:0] count_reg, count_next, kept;
    logic       pop;

    assign head_valid = count_reg != 2'd0;
    assign head       = slot_reg[0];
    assign pop        = head_valid && pop_ready;
    // Room for the two results one item can cause.
    assign has_room   = count_reg <= 2'd1;
    assign kept       = count_reg - {1'b0, pop};
    assign count_next = kept + {1'b0, push.v0} + {1'b0, push.v1};

    always_comb begin
        for (int i = 0; i < ipd_pkg::QUEUE_DEPTH; i++) begin
            if (pop && i < ipd_pkg::QUEUE_DEPTH - 1) begin
                shifted[i] = slot_reg[i + 1];
            end else begin
                shifted[i] = slot_reg[i];
            end
            if (2'(i) < kept) begin
                slot_next[i] = shifted[i];
            end else if (2'(i) == kept && push.v0) begin
                slot_next[i] = push.r0;
            end else if (2'(i) == kept + 2'd1 && push.v1) begin
                slot_next[i] = push.r1;
            end else begin
                slot_next[i] = shifted[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ipd_pkg::QUEUE_DEPTH; i++) begin
            slot_reg[i] <= slot_next[i];
        end
    end

endmodule

>>> rtl/ips_patch_stream_decoder_core.sv
// IPS / IPS32 patch stream decoder.
// Input channel (s_*): one patch file byte per item, with first_byte marking the
// start of a new file and final_byte the last byte available.
// Result channel (m_*): write, fill, done and error commands, one per item;
// m_last_of_run marks the last result caused by one input byte.
// Configuration: cfg_wr_en writes the 33-bit image size; write it
// only while the block is idle.
// Results are registered in the result queue before they appear on m_*.
// Throughput: one byte per cycle while each byte gives at most one result and
// m_ready stays high.
// A byte giving two results (a command followed by a truncation error) leaves at least
// two entries in the three-entry result queue, so s_ready drops after it.
// A result waits in the queue while m_ready is low. s_ready is high only while at
// most one result is queued, so a stalled receiver holds up the input once two are
// queued, and s_ready returns as soon as the queue is down to one entry.
// Reset clears the parser to wait for magic bytes, the image size to zero and
// the queue to empty; s_ready rises the cycle after reset is released.
`include "assert_macros.svh"

module ips_patch_stream_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [32:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_patch_byte,
    input  logic        s_first_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [31:0] m_address,
    output logic [15:0] m_length,
    output logic [7:0]  m_value,
    output logic        m_last_of_run
);

    logic                 run_reg;
    logic                 has_room;
    logic                 accept;
    ipd_pkg::ipd_push_t   push;
    ipd_pkg::ipd_result_t head;

    assign s_ready = run_reg && has_room;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
        end else begin
            run_reg <= 1'b1;
        end
    end

    ipd_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .patch_byte  (s_patch_byte),
        .first_byte  (s_first_byte),
        .final_byte  (s_final_byte),
        .push        (push)
    );

    ipd_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop_ready  (m_ready),
        .head_valid (m_valid),
        .head       (head),
        .has_room   (has_room)
    );

    assign m_kind        = head.kind;
    assign m_address     = head.address;
    assign m_length      = head.length;
    assign m_value       = head.value;
    assign m_last_of_run = head.last;

    `IPD_ASSERT(a_pair_order, aclk, aresetn, push.v1 |-> (push.v0 && !push.r0.last && push.r1.last), "second result of an item out of order")
    `IPD_ASSERT(a_status_clean, aclk, aresetn, (m_valid && m_kind != ipd_pkg::KIND_WRITE && m_kind != ipd_pkg::KIND_FILL) |-> (m_address == 32'd0 && m_length == 16'd0 && m_value == 8'd0 && m_last_of_run), "status result carries payload")
    `IPD_ASSERT(a_write_len, aclk, aresetn, (m_valid && m_kind == ipd_pkg::KIND_WRITE) |-> (m_length == 16'd1), "byte write with length other than one")
    `IPD_ASSERT_NEXT(a_no_push_when_full, aclk, aresetn, !has_room, !(($past(push.v0)) && !$past(has_room)), "result pushed into a full queue")

endmodule

>>> verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        ST_MAGIC,
        ST_OFFSET,
        ST_SIZE,
        ST_RUN_LEN,
        ST_RUN_VAL,
        ST_DATA,
        ST_ENDED
    } parse_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       fin;
    } patch_item_t;

    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 80;

    // Tracks the decoder state and holds the commands still owed by the block.
    class patch_scoreboard;
        logic [32:0]          image_size;
        parse_state_t         state;
        logic                 wide;
        int unsigned          field_cnt;
        logic [31:0]          rec_offset;
        logic [15:0]          rec_size;
        logic [15:0]          remaining;
        ipd_pkg::ipd_result_t expected[$];
        int                   mismatches;

        function new();
            image_size = '0;
            state      = ST_MAGIC;
            wide       = 1'b0;
            field_cnt  = 0;
            rec_offset = '0;
            rec_size   = '0;
            remaining  = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function ipd_pkg::ipd_result_t make_result(ipd_pkg::ipd_kind_t kind,
                                                   logic [31:0] addr,
                                                   logic [15:0] len, logic [7:0] val);
            ipd_pkg::ipd_result_t r;
            r.kind    = kind;
            r.address = addr;
            r.length  = len;
            r.value   = val;
            r.last    = 1'b0;
            return r;
        endfunction

        function void start_record();
            state      = ST_OFFSET;
            field_cnt  = 0;
            rec_offset = '0;
        endfunction

        function void note_input(logic [7:0] b, logic first, logic fin);
            ipd_pkg::ipd_result_t fresh[$];
            logic [32:0] lim;
            logic [32:0] room;
            logic [32:0] addr;
            logic [32:0] fill_len;
            logic [15:0] done_cnt;
            lim = (image_size > ipd_pkg::ADDR_SPACE) ? ipd_pkg::ADDR_SPACE : image_size;
            if (first) begin
                state      = ST_MAGIC;
                field_cnt  = 0;
                rec_offset = '0;
                wide       = 1'b0;
            end
            if (state == ST_ENDED)
                return;
            case (state)
                ST_MAGIC: begin
                    if (field_cnt < 4) begin
                        rec_offset = {rec_offset[23:0], b};
                        field_cnt++;
                    end else if (rec_offset == ipd_pkg::MAGIC_IPS_HEAD &&
                                 b == ipd_pkg::MAGIC_IPS_TAIL) begin
                        wide = 1'b0;
                        start_record();
                    end else if (rec_offset == ipd_pkg::MAGIC_I32_HEAD &&
                                 b == ipd_pkg::MAGIC_I32_TAIL) begin
                        wide = 1'b1;
                        start_record();
                    end else begin
                        fresh.insert(fresh.size(),
                                     make_result(ipd_pkg::KIND_BAD_MAGIC, '0, '0, '0));
                        state = ST_ENDED;
                    end
                end
                ST_OFFSET: begin
                    rec_offset = {rec_offset[23:0], b};
                    field_cnt++;
                    if (field_cnt >= (wide ? 4 : 3)) begin
                        field_cnt = 0;
                        if (rec_offset == (wide ? ipd_pkg::END_I32 : ipd_pkg::END_IPS)) begin
                            fresh.insert(fresh.size(),
                                         make_result(ipd_pkg::KIND_DONE, '0, '0, '0));
                            state = ST_ENDED;
                        end else begin
                            state    = ST_SIZE;
                            rec_size = '0;
                        end
                    end
                end
                ST_SIZE: begin
                    rec_size = {rec_size[7:0], b};
                    field_cnt++;
                    if (field_cnt >= 2) begin
                        field_cnt = 0;
                        if (rec_size == 0) begin
                            state     = ST_RUN_LEN;
                            remaining = '0;
                        end else begin
                            state     = ST_DATA;
                            remaining = rec_size;
                        end
                    end
                end
                ST_RUN_LEN: begin
                    remaining = {remaining[7:0], b};
                    field_cnt++;
                    if (field_cnt >= 2) begin
                        field_cnt = 0;
                        state     = ST_RUN_VAL;
                    end
                end
                ST_RUN_VAL: begin
                    // The fill is clipped at the image end; an empty fill says nothing.
                    if ({1'b0, rec_offset} < lim) begin
                        room     = lim - {1'b0, rec_offset};
                        fill_len = ({17'b0, remaining} < room) ? {17'b0, remaining} : room;
                        if (fill_len != 0)
                            fresh.insert(fresh.size(),
                                         make_result(ipd_pkg::KIND_FILL, rec_offset,
                                                     fill_len[15:0], b));
                    end
                    start_record();
                end
                ST_DATA: begin
                    done_cnt = rec_size - remaining;
                    addr     = {1'b0, rec_offset} + {17'b0, done_cnt};
                    if (addr < lim)
                        fresh.insert(fresh.size(),
                                     make_result(ipd_pkg::KIND_WRITE, addr[31:0], 16'd1, b));
                    remaining = remaining - 16'd1;
                    if (remaining == 0)
                        start_record();
                end
                default: ;
            endcase
            if (fin && state != ST_ENDED) begin
                fresh.insert(fresh.size(),
                             make_result((state == ST_MAGIC) ? ipd_pkg::KIND_BAD_MAGIC
                                                             : ipd_pkg::KIND_TRUNCATED,
                                         '0, '0, '0));
                state = ST_ENDED;
            end
            if (fresh.size() > 0) begin
                fresh[fresh.size() - 1].last = 1'b1;
                foreach (fresh[i])
                    expected.insert(expected.size(), fresh[i]);
            end
        endfunction

        function void report(string what, ipd_pkg::ipd_result_t want,
                             ipd_pkg::ipd_result_t got);
            mismatches++;
            if (mismatches <= 10)
                $display({"%0t %s: expected kind=%0d addr=%h len=%0d val=%h last=%0b,",
                          " got kind=%0d addr=%h len=%0d val=%h last=%0b"},
                         $time, what, want.kind, want.address, want.length, want.value,
                         want.last, got.kind, got.address, got.length, got.value,
                         got.last);
        endfunction

        function void check_result(ipd_pkg::ipd_result_t got);
            ipd_pkg::ipd_result_t want;
            if (expected.size() == 0) begin
                report("result with nothing expected", '0, got);
                return;
            end
            want = expected.pop_front();
            if (got.kind !== want.kind || got.address !== want.address ||
                got.length !== want.length || got.value !== want.value ||
                got.last !== want.last)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [32:0] cfg_wr_data   = '0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_patch_byte  = '0;
    logic        s_first_byte  = 1'b0;
    logic        s_final_byte  = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [2:0]  m_kind;
    logic [31:0] m_address;
    logic [15:0] m_length;
    logic [7:0]  m_value;
    logic        m_last_of_run;

    patch_scoreboard sb;
    patch_item_t     item_q[$];
    bit              idling        = 1'b1;
    bit              long_hold_req = 1'b0;
    int              hold_left     = 0;
    int              stall_cycles  = 0;

    ips_patch_stream_decoder_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_patch_byte  (s_patch_byte),
        .s_first_byte  (s_first_byte),
        .s_final_byte  (s_final_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_address     (m_address),
        .m_length      (m_length),
        .m_value       (m_value),
        .m_last_of_run (m_last_of_run)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en)
                sb.image_size = cfg_wr_data;
            if (s_valid && s_ready)
                sb.note_input(s_patch_byte, s_first_byte, s_final_byte);
            if (m_valid && m_ready)
                sb.check_result(ipd_pkg::ipd_result_t'({m_kind, m_address, m_length,
                                                        m_value, m_last_of_run}));
        end
    end

    // Receiver: random stalls while idling, plus one long hold-off on request.
    always @(negedge aclk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (idling && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 13);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic void add_field(logic [31:0] v, int n);
        patch_item_t it;
        for (int i = n - 1; i >= 0; i--) begin
            it.data  = v[8 * i +: 8];
            it.first = 1'b0;
            it.fin   = 1'b0;
            item_q.insert(item_q.size(), it);
        end
    endfunction

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic write_image_size(logic [32:0] v);
        wait_drained();
        // Bytes that give no command may still be in flight.
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_items();
        patch_item_t it;
        int          gap;
        @(negedge aclk);
        while (item_q.size() > 0) begin
            it = item_q.pop_front();
            if (idling && $urandom_range(0, 5) == 0) begin
                s_valid <= 1'b0;
                gap = $urandom_range(1, 14);
                repeat (gap) @(negedge aclk);
            end
            s_valid      <= 1'b1;
            s_patch_byte <= it.data;
            s_first_byte <= it.first;
            s_final_byte <= it.fin;
            @(posedge aclk);
            while (!s_ready)
                @(posedge aclk);
            @(negedge aclk);
        end
        s_valid <= 1'b0;
    endtask

    // Queues one patch file: mostly well formed, some cut short, corrupted or noise.
    task automatic queue_random_file(logic [32:0] size, inout int counted);
        logic [32:0] lim;
        logic [31:0] ofs;
        logic [15:0] len;
        int          start;
        int          sel;
        int          n;
        int          cut;
        logic        wide;
        lim   = (size > ipd_pkg::ADDR_SPACE) ? ipd_pkg::ADDR_SPACE : size;
        wide  = $urandom_range(0, 1);
        start = item_q.size();
        sel   = $urandom_range(0, 19);
        if (sel == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) add_field($urandom(), 1);
            item_q[start].first = $urandom_range(0, 1);
            item_q[item_q.size() - 1].fin = ($urandom_range(0, 3) == 0);
            counted += n;
            return;
        end
        add_field(wide ? ipd_pkg::MAGIC_I32_HEAD : ipd_pkg::MAGIC_IPS_HEAD, 4);
        add_field(wide ? ipd_pkg::MAGIC_I32_TAIL : ipd_pkg::MAGIC_IPS_TAIL, 1);
        item_q[start].first = 1'b1;
        if (sel == 1) begin
            cut = start + $urandom_range(0, 4);
            item_q[cut].data = item_q[cut].data ^ (8'd1 << $urandom_range(0, 7));
            counted += 5;
            return;
        end
        if (sel == 2) begin
            cut = start + $urandom_range(0, 3);
            while (item_q.size() > cut + 1)
                void'(item_q.pop_back());
            item_q[cut].fin = 1'b1;
            counted += cut - start + 1;
            return;
        end
        n = $urandom_range(1, 4);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: ofs = $urandom_range(0, 63);
                1: ofs = lim[31:0] - $urandom_range(0, 4);
                2: ofs = $urandom();
                default: ofs = 32'hFFFF_FFFF - $urandom_range(0, 6);
            endcase
            if (!wide)
                ofs[31:24] = 8'h00;
            if (ofs == (wide ? ipd_pkg::END_I32 : ipd_pkg::END_IPS))
                ofs[0] = ~ofs[0];
            add_field(ofs, wide ? 4 : 3);
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 3))
                    0: len = 16'd0;
                    1: len = $urandom_range(1, 16);
                    2: len = 16'hFFFF;
                    default: len = $urandom();
                endcase
                add_field(32'd0, 2);
                add_field(len, 2);
                add_field($urandom(), 1);
            end else if ($urandom_range(0, 9) == 0) begin
                // A long literal record, always cut short by a final byte.
                add_field($urandom_range(7, 65535), 2);
                repeat ($urandom_range(1, 5)) add_field($urandom(), 1);
                item_q[item_q.size() - 1].fin = 1'b1;
                counted += item_q.size() - start;
                return;
            end else begin
                len = $urandom_range(1, 6);
                add_field(len, 2);
                repeat (len) add_field($urandom(), 1);
            end
        end
        sel = $urandom_range(0, 9);
        if (sel < 2) begin
            cut = $urandom_range(start, item_q.size() - 1);
            while (item_q.size() > cut + 1)
                void'(item_q.pop_back());
            item_q[cut].fin = 1'b1;
            counted += cut - start + 1;
        end else if (sel == 2) begin
            // Abandoned: the file stops mid-record, and the decoder restarts only at a later first byte.
            counted += item_q.size() - start;
        end else begin
            add_field(wide ? ipd_pkg::END_I32 : ipd_pkg::END_IPS, wide ? 4 : 3);
            if ($urandom_range(0, 2) == 0)
                item_q[item_q.size() - 1].fin = 1'b1;
            counted += item_q.size() - start;
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) add_field($urandom(), 1);
                item_q[item_q.size() - 1].fin = $urandom_range(0, 1);
            end
        end
    endtask

    task automatic run_phase(logic [32:0] size, int quota, bit idle, bit hold, bit pause);
        int counted;
        counted = 0;
        write_image_size(size);
        idling = idle;
        if (hold)
            long_hold_req = 1'b1;
        while (counted < quota / 2)
            queue_random_file(size, counted);
        send_items();
        if (pause)
            wait_drained();
        while (counted < quota)
            queue_random_file(size, counted);
        send_items();
    endtask

    initial begin
        logic [32:0] rnd_size;
        int          head;
        sb = new();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        write_image_size(33'd18);
        // No first byte after reset; the third literal byte lands past the image end,
        // and the byte after the end marker is ignored.
        add_field(ipd_pkg::MAGIC_IPS_HEAD, 4);
        add_field(ipd_pkg::MAGIC_IPS_TAIL, 1);
        add_field(32'd16, 3);
        add_field(32'd3, 2);
        add_field(32'h00FF_0011, 3);
        add_field(ipd_pkg::END_IPS, 3);
        add_field(32'hA5, 1);
        item_q[item_q.size() - 1].fin = 1'b1;
        // Magic cut short after one byte.
        head = item_q.size();
        add_field(32'h58, 1);
        item_q[head].first = 1'b1;
        item_q[head].fin   = 1'b1;
        // Wide offsets, a clipped fill, and a final byte that also truncates.
        head = item_q.size();
        add_field(ipd_pkg::MAGIC_I32_HEAD, 4);
        add_field(ipd_pkg::MAGIC_I32_TAIL, 1);
        add_field(32'd5, 4);
        add_field(32'd0, 2);
        add_field(32'hFFFF, 2);
        add_field(32'h7E, 1);
        item_q[head].first = 1'b1;
        item_q[item_q.size() - 1].fin = 1'b1;
        send_items();

        rnd_size = {1'($urandom_range(0, 1)), 32'($urandom())};
        run_phase(33'd0, 50, 1'b1, 1'b0, 1'b0);
        run_phase(33'd40, 60, 1'b1, 1'b1, 1'b0);
        run_phase(33'h1_0000_0000, 60, 1'b1, 1'b0, 1'b1);
        run_phase(33'h1_FFFF_FFFF, 50, 1'b1, 1'b0, 1'b0);
        run_phase(rnd_size, 60, 1'b1, 1'b0, 1'b0);
        run_phase(33'h0_FFFF_FFFF, 50, 1'b1, 1'b0, 1'b0);
        run_phase(33'd1000, 60, 1'b0, 1'b0, 1'b0);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
